FILE: rtl/core/imd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imd_pkg
// Shared types and constants of the integer matrix determinant block.
// ----------------------------------------------------------------------------
package imd_pkg;

    localparam int CFG_W  = 4;
    localparam int ELEM_W = 8;
    localparam int DET_W  = 64;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_FETCH,
        ST_MUL,
        ST_ACC,
        ST_STORE
    } state_t;

endpackage
`default_nettype wire

FILE: rtl/core/integer_matrix_determinant.sv
`default_nettype none
// ----------------------------------------------------------------------------
// integer_matrix_determinant
// Determinant of a square signed matrix, row-wise Laplace expansion over
// column subsets held in a minor table memory; result wraps modulo 2^64.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_data) sets the side length n; 0 reads
//   as 1, values above MAX_SIZE saturate. A write restarts the matrix.
//   in channel (in_valid/in_stall/element) takes entries in row-major order,
//   one per cycle while a row is being loaded and no cfg write is pending.
//   out channel (out_valid/out_stall/determinant) gives one request per matrix.
// Operation:
//   After the last entry of row r the sequencer walks the 2^n - 1 nonempty
//   column sets and, for each set of r+1 columns, walks the columns and, for
//   each chosen column, reads the minor table, multiplies and accumulates,
//   then writes the minor back. in_stall is high for that time.
//   The minor table has a single port pair, one write and one read.
// Reset puts the block at the start of a matrix with n = 2; the minor table
// is not cleared, every entry is written before it is read.
// A stalled result sits in the output register; the next matrix loads behind
// it and only its final write-back waits until the register is free.
// ----------------------------------------------------------------------------
module integer_matrix_determinant #(
    parameter int MAX_SIZE = 10
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [imd_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic signed [imd_pkg::ELEM_W-1:0] element,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic signed [imd_pkg::DET_W-1:0]     determinant
);

    localparam int IW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int SW    = $clog2(MAX_SIZE + 1);
    localparam int MW    = MAX_SIZE;
    localparam int DEPTH = 1 << MAX_SIZE;
    localparam int PW    = imd_pkg::DET_W + imd_pkg::ELEM_W;

    imd_pkg::state_t state_reg, state_next;

    logic [imd_pkg::CFG_W-1:0]  size_reg, size_next;
    logic [IW-1:0]              col_reg, col_next;
    logic [IW-1:0]              row_reg, row_next;
    logic [IW-1:0]              j_reg, j_next;
    logic [MW-1:0]              s_reg, s_next;
    logic [imd_pkg::DET_W-1:0]  acc_reg, acc_next;
    logic [imd_pkg::DET_W-1:0]  prod_reg, prod_next;
    logic                       neg_reg, neg_next;
    logic                       out_valid_reg, out_valid_next;
    logic [imd_pkg::DET_W-1:0]  det_reg, det_next;

    logic signed [imd_pkg::ELEM_W-1:0] row_store [MAX_SIZE];
    logic [imd_pkg::DET_W-1:0]         minor_mem [DEPTH];
    logic [imd_pkg::DET_W-1:0]         rd_data_reg;

    logic                       mem_we;
    logic [MW-1:0]              mem_waddr;
    logic [imd_pkg::DET_W-1:0]  mem_wdata;
    logic                       mem_re;
    logic [MW-1:0]              mem_raddr;

    logic [IW-1:0]              n_m1;
    logic [MW-1:0]              last_s;
    logic [SW-1:0]              pc_s;
    logic [SW-1:0]              row_p1;
    logic                       par;
    logic                       in_acc;
    logic                       cfg_acc;
    logic                       out_free;
    logic                       set_match;
    logic                       j_last;
    logic                       s_last;
    logic                       s_has_j;
    logic signed [PW-1:0]       prod_full;

    // side length in use and the full column set
    always_comb
    begin
        int unsigned nsz;
        nsz = 32'(size_reg);
        if (nsz == 0)
            nsz = 1;
        if (nsz > MAX_SIZE)
            nsz = MAX_SIZE;
        n_m1   = IW'(nsz - 1);
        last_s = MW'((33'd1 << nsz) - 33'd1);
    end

    // column set size, and sign parity of chosen columns at or above j
    always_comb
    begin
        pc_s = '0;
        par  = 1'b0;
        for (int i = 0; i < MW; i++)
        begin
            pc_s = pc_s + SW'(s_reg[i]);
            if (i >= int'(j_reg))
                par = par ^ s_reg[i];
        end
    end

    assign row_p1    = SW'(row_reg) + SW'(1);
    assign set_match = (pc_s == row_p1);
    assign j_last    = (j_reg == n_m1);
    assign s_last    = (s_reg == last_s);
    assign s_has_j   = s_reg[j_reg];
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = (state_reg == imd_pkg::ST_LOAD);
    assign in_stall  = (state_reg != imd_pkg::ST_LOAD) || cfg_valid;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign in_acc    = in_valid && !in_stall;
    assign prod_full = $signed(rd_data_reg) * row_store[j_reg];

    assign out_valid   = out_valid_reg;
    assign determinant = det_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            imd_pkg::ST_LOAD:
                if (in_acc && col_reg == n_m1)
                    state_next = imd_pkg::ST_SCAN;
            imd_pkg::ST_SCAN:
                if (set_match)
                    state_next = imd_pkg::ST_FETCH;
                else if (s_last)
                    state_next = imd_pkg::ST_LOAD;
            imd_pkg::ST_FETCH:
                if (s_has_j)
                    state_next = imd_pkg::ST_MUL;
                else if (j_last)
                    state_next = imd_pkg::ST_STORE;
            imd_pkg::ST_MUL:
                state_next = imd_pkg::ST_ACC;
            imd_pkg::ST_ACC:
                state_next = j_last ? imd_pkg::ST_STORE : imd_pkg::ST_FETCH;
            imd_pkg::ST_STORE:
                if (!s_last)
                    state_next = imd_pkg::ST_SCAN;
                else if (row_reg != n_m1 || out_free)
                    state_next = imd_pkg::ST_LOAD;
            default:
                state_next = imd_pkg::ST_LOAD;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        size_next      = size_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        j_next         = j_reg;
        s_next         = s_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        det_next       = det_reg;
        out_valid_next = out_valid_reg && out_stall;
        mem_we         = 1'b0;
        mem_waddr      = s_reg;
        mem_wdata      = acc_reg;
        mem_re         = 1'b0;
        mem_raddr      = s_reg ^ (MW'(1) << j_reg);

        case (state_reg)
            imd_pkg::ST_LOAD:
                if (cfg_acc)
                begin
                    size_next = cfg_data;
                    col_next  = '0;
                    row_next  = '0;
                end
                else if (in_acc)
                begin
                    if (col_reg == n_m1)
                    begin
                        col_next = '0;
                        s_next   = MW'(1);
                        j_next   = '0;
                        // empty-set minor
                        if (row_reg == '0)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = '0;
                            mem_wdata = imd_pkg::DET_W'(1);
                        end
                    end
                    else
                        col_next = col_reg + IW'(1);
                end
            imd_pkg::ST_SCAN:
                if (set_match)
                begin
                    acc_next = '0;
                    j_next   = '0;
                end
                else if (s_last)
                    row_next = row_reg + IW'(1);
                else
                    s_next = s_reg + MW'(1);
            imd_pkg::ST_FETCH:
                if (s_has_j)
                    mem_re = 1'b1;
                else if (!j_last)
                    j_next = j_reg + IW'(1);
            imd_pkg::ST_MUL:
            begin
                prod_next = prod_full[imd_pkg::DET_W-1:0];
                // even count of chosen columns at or right of j: subtract
                neg_next  = !par;
            end
            imd_pkg::ST_ACC:
            begin
                acc_next = neg_reg ? acc_reg - prod_reg : acc_reg + prod_reg;
                if (!j_last)
                    j_next = j_reg + IW'(1);
            end
            imd_pkg::ST_STORE:
            begin
                mem_we = 1'b1;
                if (!s_last)
                    s_next = s_reg + MW'(1);
                else if (row_reg != n_m1)
                    row_next = row_reg + IW'(1);
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    det_next       = acc_reg;
                    row_next       = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= imd_pkg::ST_LOAD;
            size_reg      <= imd_pkg::CFG_W'(2);
            col_reg       <= '0;
            row_reg       <= '0;
            j_reg         <= '0;
            s_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            j_reg         <= j_next;
            s_reg         <= s_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
        det_reg  <= det_next;
        if (in_acc)
            row_store[col_reg] <= element;
    end

    // minor table, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            minor_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= minor_mem[mem_raddr];
    end

    // a minor is written back only for a set one column larger than the row
    a_store_size: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == imd_pkg::ST_STORE) |-> (pc_s == row_p1))
        else $error("minor write-back for a column set of the wrong size");

    // a product is formed only from a read issued the cycle before
    a_mul_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == imd_pkg::ST_MUL) |-> $past(mem_re))
        else $error("multiply without a preceding minor read");

    // reads of row r minors never hit the entry being written
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("minor table read and write to the same entry");

    // load counters stay inside the matrix
    a_load_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == imd_pkg::ST_LOAD) |-> (col_reg <= n_m1 && row_reg <= n_m1))
        else $error("element position outside the matrix");

    // a result is raised only by the final write-back
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == imd_pkg::ST_STORE))
        else $error("result raised outside the final write-back");

endmodule
`default_nettype wire

FILE: dv/determinant_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// determinant_checker
// Watches the config, element and result channels of the determinant block,
// rebuilds each matrix from the accepted elements, works out its determinant
// modulo 2^64 and compares every accepted result with the oldest one due.
// ----------------------------------------------------------------------------
module determinant_checker
    import imd_pkg::*;
#(
    parameter int MAX_SIZE = 10
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    input  wire logic                     cfg_ready,
    input  wire logic [CFG_W-1:0]         cfg_data,
    input  wire logic                     in_valid,
    input  wire logic                     in_stall,
    input  wire logic signed [ELEM_W-1:0] element,
    input  wire logic                     out_valid,
    input  wire logic                     out_stall,
    input  wire logic signed [DET_W-1:0]  determinant,
    output int                            pending,
    output int                            error_count
);

    localparam int SETS = 1 << MAX_SIZE;

    logic [CFG_W-1:0] side_code;
    int unsigned      position;
    int               fails;
    logic [DET_W-1:0] row_entries [MAX_SIZE];
    logic [DET_W-1:0] minors [SETS];
    logic [DET_W-1:0] expected_determinants [$];

    function automatic int unsigned side_length(input logic [CFG_W-1:0] code);
        if (code == 0)
            return 1;
        if (code > MAX_SIZE)
            return MAX_SIZE;
        return code;
    endfunction

    // Row r is complete: fill the minor of every column set with r+1 members.
    function automatic void expand_completed_row(input int unsigned r, input int unsigned n);
        logic [DET_W-1:0] acc;
        logic [DET_W-1:0] term;
        if (r == 0)
            minors[0] = 64'd1;
        for (int unsigned s = 1; s < (1 << n); s++)
        begin
            if ($countones(s) != r + 1)
                continue;
            acc = '0;
            for (int unsigned j = 0; j < n; j++)
            begin
                if (s[j] == 1'b0)
                    continue;
                term = row_entries[j] * minors[s ^ (1 << j)];
                // sign set by how many chosen columns lie right of j
                if ((($countones(s >> j) - 1) % 2) == 1)
                    acc = acc - term;
                else
                    acc = acc + term;
            end
            minors[s] = acc;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int unsigned      n;
        int unsigned      row;
        int unsigned      col;
        logic [DET_W-1:0] want;
        if (!rst_n)
        begin
            side_code = 4'd2;
            position  = 0;
            fails     = 0;
            expected_determinants.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                side_code = cfg_data;
                position  = 0;
            end
            if (in_valid && !in_stall)
            begin
                n = side_length(side_code);
                if (position >= n * n)
                    position = 0;
                row = position / n;
                col = position % n;
                row_entries[col] = {{(DET_W - ELEM_W){element[ELEM_W-1]}}, element};
                position++;
                if (col + 1 == n)
                begin
                    expand_completed_row(row, n);
                    if (row + 1 == n)
                    begin
                        expected_determinants.push_back(minors[(1 << n) - 1]);
                        position = 0;
                    end
                end
            end
            if (out_valid && !out_stall)
            begin
                if (expected_determinants.size() == 0)
                begin
                    $error("determinant: unexpected request, expected none, actual %0d",
                           determinant);
                    fails++;
                end
                else
                begin
                    want = expected_determinants.pop_front();
                    if (determinant !== want)
                    begin
                        $error("determinant mismatch: expected %0d, actual %0d",
                               $signed(want), determinant);
                        fails++;
                    end
                end
            end
        end
        pending     <= expected_determinants.size();
        error_count <= fails;
    end

endmodule
`default_nettype wire

FILE: dv/integer_matrix_determinant_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// integer_matrix_determinant_tb
// Drives matrices of every side length through the determinant block with
// random gaps on the element side and random stalls on the result side; a
// checker beside the block predicts and compares each determinant.
// ----------------------------------------------------------------------------
module integer_matrix_determinant_tb;
    import imd_pkg::*;

    localparam int MAX_SIZE        = 10;
    localparam int ELEMENTS_TARGET = 1100;
    localparam int QUIET_LIMIT     = 200000;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_W-1:0]         cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic signed [ELEM_W-1:0] element   = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DET_W-1:0]  determinant;

    int          pending;
    int          error_count;
    bit          calm          = 1'b0;
    int unsigned elements_sent = 0;
    int unsigned side          = 2;

    integer_matrix_determinant #(
        .MAX_SIZE(MAX_SIZE)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .element    (element),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .determinant(determinant)
    );

    determinant_checker #(
        .MAX_SIZE(MAX_SIZE)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .element    (element),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .determinant(determinant),
        .pending    (pending),
        .error_count(error_count)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic int unsigned effective_side(input logic [CFG_W-1:0] code);
        if (code == 0)
            return 1;
        if (code > MAX_SIZE)
            return MAX_SIZE;
        return code;
    endfunction

    // Upper bound on one row expansion, with every set scanned and walked.
    function automatic int unsigned busy_cycles(input int unsigned n);
        return (1 << n) * (3 * n + 3) + 32;
    endfunction

    function automatic logic signed [ELEM_W-1:0] pick_element();
        case ($urandom_range(0, 9))
            0:       return ELEM_W'(-128);
            1:       return ELEM_W'(127);
            2:       return ELEM_W'(0);
            3:       return ELEM_W'($urandom_range(0, 6) - 3);
            default: return ELEM_W'($urandom());
        endcase
    endfunction

    task automatic send_element(input logic signed [ELEM_W-1:0] value);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        element  <= value;
        do @(posedge clk); while (in_stall);
        elements_sent++;
    endtask

    task automatic send_matrix(input int unsigned n);
        repeat (n * n) send_element(pick_element());
    endtask

    // Block must be idle: any row expansion finished and results drained.
    task automatic write_size(input logic [CFG_W-1:0] code);
        in_valid <= 1'b0;
        repeat (busy_cycles(side)) @(posedge clk);
        while (pending != 0) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= code;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        side = effective_side(code);
    endtask

    // Result side: random stall before each request.
    initial
    begin
        int unsigned hold;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, 16);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("integer_matrix_determinant_tb: errors");
        $finish;
    end

    initial
    begin
        logic [CFG_W-1:0] big_codes [4];
        logic [CFG_W-1:0] code;
        int unsigned      phase;
        int unsigned      count;
        big_codes = '{4'd10, 4'd15, 4'd0, 4'd12};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // side length 2 out of reset, extreme entries
        send_element(ELEM_W'(127));
        send_element(ELEM_W'(-128));
        send_element(ELEM_W'(-128));
        send_element(ELEM_W'(127));
        // one by one: determinant is the entry itself
        write_size(4'd1);
        send_element(ELEM_W'(-128));
        send_element(ELEM_W'(127));
        send_element(ELEM_W'(0));
        // size code zero reads as one
        write_size(4'd0);
        send_element(ELEM_W'(-1));
        // partly loaded matrix, dropped by the size write after it
        write_size(4'd3);
        repeat (4) send_element(pick_element());
        write_size(4'd2);
        repeat (4) send_element(ELEM_W'(-128));

        phase = 0;
        while (elements_sent < ELEMENTS_TARGET)
        begin
            if (phase < 4)
                code = big_codes[phase];
            else if ($urandom_range(0, 7) == 0)
                code = CFG_W'($urandom_range(6, 9));
            else
                code = CFG_W'($urandom_range(1, 5));
            calm = ($urandom_range(0, 3) == 0);
            write_size(code);
            count = (side >= 6) ? 1 : $urandom_range(2, 6);
            repeat (count) send_matrix(side);
            // now and then leave a matrix unfinished before the next size write
            if (side > 1 && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, side * side - 1)) send_element(pick_element());
            phase++;
        end

        in_valid <= 1'b0;
        repeat (busy_cycles(side)) @(posedge clk);
        while (pending != 0) @(posedge clk);
        @(posedge clk);
        if (error_count == 0)
            $display("integer_matrix_determinant_tb: clean");
        else
            $display("integer_matrix_determinant_tb: errors");
        $finish;
    end

endmodule
`default_nettype wire

FILE: files.f
rtl/core/imd_pkg.sv
rtl/core/integer_matrix_determinant.sv
dv/determinant_checker.sv
dv/integer_matrix_determinant_tb.sv
